/* design/tabular_q_lambda_update_assert.svh */
// assertion macros for the q(lambda) learner
`ifndef TABULAR_Q_LAMBDA_UPDATE_ASSERT_SVH
`define TABULAR_Q_LAMBDA_UPDATE_ASSERT_SVH

// a condition implies another in the same cycle
`define QL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// a condition implies another in the cycle after
`define QL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/tql_pkg.sv */
`default_nettype none
package tql_pkg;
  localparam int QW = 32;
  localparam int TW = 16;
  localparam int FW = 16;
  localparam int PW = 7;
  localparam logic [FW-1:0] DISCOUNT_RST = 16'd58982;
  localparam logic [FW-1:0] DECAY_RST    = 16'd6554;
  localparam logic [FW-1:0] LEARN_RST    = 16'd6554;
  localparam logic [PW-1:0] EXPLORE_RST  = 7'd20;
  localparam logic [1:0] REG_DISCOUNT = 2'd0;
  localparam logic [1:0] REG_DECAY    = 2'd1;
  localparam logic [1:0] REG_LEARN    = 2'd2;
  localparam logic [1:0] REG_EXPLORE  = 2'd3;
  localparam logic [TW-1:0] TRACE_STEP = 16'd256;

  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[QW-1:0];
  endfunction
endpackage
`default_nettype wire

/* design/tql_sweep.sv */
`default_nettype none
// per-entry update datapath: one register stage after the memory read
module tql_sweep (
  input  wire logic                          clk,
  input  wire logic signed [63:0]            upd,
  input  wire logic [15:0]                   decay,
  input  wire logic                          keep,
  input  wire logic signed [tql_pkg::QW-1:0] q_in,
  input  wire logic [tql_pkg::TW-1:0]        t_in,
  output logic signed [tql_pkg::QW-1:0]      q_out,
  output logic [tql_pkg::TW-1:0]             t_out
);
  import tql_pkg::*;
  // upd times trace is within about 2^49; product split into two halves
  logic signed [63:0] plo, phi;
  logic signed [QW-1:0] q_d;
  logic [31:0] tdec;
  logic signed [79:0] prod;
  always_ff @(posedge clk) begin
    plo  <= $signed({1'b0, upd[23:0]}) * $signed({1'b0, t_in});
    phi  <= $signed(upd[63:24]) * $signed({1'b0, t_in});
    q_d  <= q_in;
    tdec <= {16'd0, t_in} * {16'd0, decay};
  end
  always_comb begin
    prod = (80'(phi) <<< 24) + 80'(plo);
    q_out = sat32(64'(q_d) + 64'(prod >>> 8));
    t_out = keep ? tdec[31:16] : '0;
  end
endmodule
`default_nettype wire

/* design/tabular_q_lambda_update.sv */
`default_nettype none
// tabular watkins q(lambda) learner. each input beat carries a grid position, a
// reward, a legal-move mask and random draws; one output beat returns the chosen
// action. q values (signed q16.16) and traces (unsigned q8.8) sit in two
// simple dual-port synchronous memories of ACTION_COUNT*GRID_ROWS*GRID_COLS
// entries. the first beat after reset runs a clearing sweep over both memories
// (one entry per cycle) and answers the greedy action. every later beat reads
// the candidate q values one per cycle, forms target and update, bumps the
// previous trace, then sweeps all entries once, one per cycle, through a
// three-stage read-modify-write pipe. the user must write configuration
// only while no beat is in flight; the block itself does not enforce this.
module tabular_q_lambda_update #(
  parameter int GRID_ROWS    = 16,
  parameter int GRID_COLS    = 16,
  parameter int ACTION_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pos_row[3:0] pos_col[7:4] reward[23:8] move_mask[27:24]
  // rand_percent[34:28] rand_action[36:35] zero pad[39:37]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // chosen_action[1:0] zero pad[7:2]
  output logic [7:0]       m_tdata
);
  import tql_pkg::*;
  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int AW = (ACTION_COUNT > 2) ? 2 : 1;
  localparam int SIZE = ACTION_COUNT * GRID_ROWS * GRID_COLS;
  localparam int IW = $clog2(SIZE);

  localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_GRD = 3'd2,
    S_TGT = 3'd3, S_UPD = 3'd4, S_SWP = 3'd5, S_OUT = 3'd6;

  logic [2:0] state;
  logic [FW-1:0] discount, trace_decay, learn_rate;
  logic [PW-1:0] explore_percent;
  logic started;
  logic [RW-1:0] prev_row, row;
  logic [CW-1:0] prev_col, col;
  logic [AW-1:0] prev_action, action, best_a, ract;
  logic signed [QW-1:0] best, qmax, qprev;
  logic found, first;
  logic [3:0] mask;
  logic signed [15:0] reward;
  logic [PW-1:0] rpct;
  logic [IW:0] cnt;
  logic [2:0] ph;
  logic signed [QW-1:0] target;
  logic signed [63:0] upd;
  logic [15:0] decay;
  logic keep;

  logic signed [QW-1:0] qmem [SIZE];
  logic [TW-1:0] tmem [SIZE];
  logic [IW-1:0] raddr, waddr;
  logic signed [QW-1:0] qrd, qwd;
  logic [TW-1:0] trd, twd;
  logic we;

  always_ff @(posedge clk) begin
    if (we) begin
      qmem[waddr] <= qwd;
      tmem[waddr] <= twd;
    end
    qrd <= qmem[raddr];
    trd <= tmem[raddr];
  end

  function automatic logic [IW-1:0] ent(input logic [AW-1:0] a, input logic [RW-1:0] r,
                                        input logic [CW-1:0] c);
    ent = IW'((32'(a) * GRID_ROWS + 32'(r)) * GRID_COLS + 32'(c));
  endfunction

  // clamped position of the incoming beat
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  always_comb begin
    in_row = (32'(s_tdata[3:0]) >= GRID_ROWS) ? RW'(GRID_ROWS - 1) : RW'(s_tdata[3:0]);
    in_col = (32'(s_tdata[7:4]) >= GRID_COLS) ? CW'(GRID_COLS - 1) : CW'(s_tdata[7:4]);
  end

  // sweep pipe: read at cnt, data at cnt-1, written back at cnt-2
  logic signed [QW-1:0] q_new;
  logic [TW-1:0] t_new;
  logic [IW-1:0] wa1, wa2;
  logic v1, v2;
  tql_sweep u_sweep (
    .clk(clk), .upd(upd), .decay(decay), .keep(keep),
    .q_in(qrd), .t_in(trd), .q_out(q_new), .t_out(t_new)
  );

  // trace bump of the previous entry lands before the sweep reads it
  logic bump_we;
  logic [TW-1:0] bump_t;
  logic [IW-1:0] pidx;
  assign pidx = ent(prev_action, prev_row, prev_col);

  always_comb begin
    raddr = cnt[IW-1:0];
    if (state == S_GRD) raddr = ent(AW'(cnt), row, col);
    else if (state == S_TGT) raddr = ent(best_a, row, col);
    else if (state == S_UPD) raddr = pidx;
    we = 1'b0; waddr = cnt[IW-1:0]; qwd = '0; twd = '0;
    if (state == S_CLR) we = 1'b1;
    else if (bump_we) begin
      we = 1'b1; waddr = pidx; qwd = qprev; twd = bump_t;
    end else if (v2) begin
      we = 1'b1; waddr = wa2; qwd = q_new; twd = t_new;
    end
  end

  logic signed [63:0] gq, diff;
  assign gq = (64'(signed'({1'b0, discount})) * 64'(qmax)) >>> 16;
  assign diff = 64'(target) - 64'(qprev);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {6'd0, 2'(prev_action)};

  always_ff @(posedge clk) begin
    bump_we <= 1'b0;
    v1 <= 1'b0;
    v2 <= v1;
    wa2 <= wa1;
    if (rst) begin
      state <= S_IDLE; started <= 1'b0;
      prev_row <= '0; prev_col <= '0; prev_action <= '0;
      discount <= DISCOUNT_RST; trace_decay <= DECAY_RST;
      learn_rate <= LEARN_RST; explore_percent <= EXPLORE_RST;
      cnt <= '0; ph <= '0; v2 <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DISCOUNT: discount <= cfg_data;
          REG_DECAY:    trace_decay <= cfg_data;
          REG_LEARN:    learn_rate <= cfg_data;
          REG_EXPLORE:  explore_percent <= cfg_data[PW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (s_tvalid) begin
          row <= in_row; col <= in_col;
          reward <= signed'(s_tdata[23:8]);
          mask <= s_tdata[27:24];
          rpct <= s_tdata[34:28];
          // draw of 0..3 folded into the action range by one subtract
          ract <= (32'(s_tdata[36:35]) >= ACTION_COUNT)
            ? AW'(32'(s_tdata[36:35]) - ACTION_COUNT) : AW'(s_tdata[36:35]);
          cnt <= '0; ph <= '0;
          first <= !started;
          found <= 1'b0; best_a <= '0; best <= '0;
          state <= started ? S_GRD : S_CLR;
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (IW+1)'(SIZE - 1)) begin
            cnt <= '0; started <= 1'b1; state <= S_GRD;
          end
        end
        S_GRD: begin
          // read of action cnt issued; data of cnt-1 in qrd
          if (cnt != 0 && mask[cnt[1:0] - 2'd1]
              && (!found || qrd >= best)) begin
            best <= qrd; best_a <= AW'(cnt - 1'b1); found <= 1'b1;
          end
          cnt <= cnt + 1'b1;
          if (cnt == (IW+1)'(ACTION_COUNT)) begin
            cnt <= '0;
            if (first) begin
              prev_action <= (!found && !(mask[cnt[1:0] - 2'd1] && ((!found) || qrd >= best)))
                ? '0 : ((mask[cnt[1:0]-2'd1] && (!found || qrd >= best))
                ? AW'(cnt - 1'b1) : best_a);
              prev_row <= row; prev_col <= col;
              state <= S_OUT;
            end else state <= S_TGT;
          end
        end
        S_TGT: begin
          // ph0 read qmax, ph1 data, ph2 target, ph3 action and decay
          ph <= ph + 1'b1;
          if (ph == 3'd1) qmax <= qrd;
          if (ph == 3'd2) target <= sat32(64'(signed'({reward, 8'd0})) + gq);
          if (ph == 3'd3) begin
            ph <= '0; state <= S_UPD;
            action <= (rpct < explore_percent) ? ract : best_a;
            keep <= !(rpct < explore_percent) || (ract == best_a);
            decay <= 16'((32'(trace_decay) * 32'(discount)) >> 16);
          end
        end
        S_UPD: begin
          ph <= ph + 1'b1;
          if (ph == 3'd1) begin
            qprev <= qrd;
            bump_t <= (trd > 16'hFFFF - TRACE_STEP) ? 16'hFFFF : trd + TRACE_STEP;
            bump_we <= 1'b1;
          end
          if (ph == 3'd2) upd <= (64'(signed'({1'b0, learn_rate})) * diff) >>> 16;
          if (ph == 3'd3) begin
            ph <= '0; cnt <= '0; state <= S_SWP;
          end
        end
        S_SWP: begin
          if (cnt < (IW+1)'(SIZE)) cnt <= cnt + 1'b1;
          v1 <= (cnt < (IW+1)'(SIZE));
          wa1 <= cnt[IW-1:0];
          if (cnt == (IW+1)'(SIZE) && !v1 && !v2) begin
            prev_row <= row; prev_col <= col; prev_action <= action;
            state <= S_OUT;
          end
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // wa1 is registered alongside the read data; q/t follow in the cycle after, from the sweep register
  `include "tabular_q_lambda_update_assert.svh"
  `QL_ASSERT_IMPLY(a_no_overlap, s_tready, !m_tvalid)
  `QL_ASSERT_IMPLY(a_bump_not_sweep, bump_we, !v2)
  `QL_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid)
endmodule
`default_nettype wire
